FILE: rtl/iprt_pkg.sv
// Shared types, constants and register indexes for the IPv4 rewrite/tunnel block.
`default_nettype none

package iprt_pkg;

  // Frame geometry
  localparam int HEADER_BYTES        = 34;
  localparam int ETH_BYTES           = 14;
  localparam int TUN_BYTES           = 20;
  localparam int IMAGE_BYTES         = HEADER_BYTES + TUN_BYTES;
  localparam int CNT_BITS            = $clog2(IMAGE_BYTES + 1);
  localparam int LENGTH_BITS_DEFAULT = 16;

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  // Byte offsets inside the captured header
  localparam int ETYPE_HI    = 12;
  localparam int ETYPE_LO    = 13;
  localparam int VER_IHL_POS = 14;
  localparam int LEN_HI      = 16;
  localparam int LEN_LO      = 17;
  localparam int PROTO_POS   = 23;
  localparam int DST_POS     = 30;

  // Byte offsets inside the outer IP header
  localparam int OUT_LEN_HI = 2;
  localparam int OUT_TTL    = 8;
  localparam int OUT_PROTO  = 9;
  localparam int OUT_SRC    = 12;
  localparam int OUT_DST    = 16;

  // Protocol constants
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'h06;
  localparam logic [7:0]  PROTO_UDP      = 8'h11;
  localparam logic [7:0]  PROTO_IPIP     = 8'h04;
  localparam logic [7:0]  VER_IHL        = 8'h45;
  localparam logic [7:0]  OUTER_TTL      = 8'hFE;
  localparam logic [3:0]  IHL_MIN        = 4'd5;
  localparam logic [15:0] MTU_RESET      = 16'd1514;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_DST_REWRITE_EN = 3'd0,
    CFG_NEW_DST_ADDR   = 3'd1,
    CFG_TUNNEL_EN      = 3'd2,
    CFG_OUTER_SRC      = 3'd3,
    CFG_OUTER_DST      = 3'd4,
    CFG_MTU_LIMIT      = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_COLLECT    = 2'd0,
    PH_DROP       = 2'd1,
    PH_STREAM     = 2'd2,
    PH_STREAM_CUT = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        frame_end;
    logic [15:0] wire_length;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_end;
    logic [15:0] out_wire_length;
  } out_beat_t;

  typedef struct packed {
    logic        dst_rewrite_enable;
    logic [31:0] new_dst_addr;
    logic        tunnel_enable;
    logic [31:0] outer_src_addr;
    logic [31:0] outer_dst_addr;
    logic [15:0] mtu_limit;
  } cfg_t;

  typedef logic [HEADER_BYTES-1:0][7:0] hdr_bytes_t;
  typedef logic [IMAGE_BYTES-1:0][7:0]  image_t;

  // Result of header processing, consumed by the frame controller
  typedef struct packed {
    image_t                image;
    logic [CNT_BITS-1:0]   count;
    logic                  last;
    logic                  pass;
    logic                  cut;
    logic [15:0]           wire_length;
  } build_t;

  // Beat offered to the output register
  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } push_t;

endpackage

`default_nettype wire

FILE: rtl/ipv4_packet_rewrite_tunnel_top.sv
// Top level of the IPv4 frame rewriter with IP-in-IP encapsulation.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  input    | in_valid / in_ready  | in_beat: data_byte, frame_end, wire_length
//  output   | out_valid / out_ready| out_beat: out_byte, out_end, out_wire_length
//  config   | cfg_we               | cfg_index, cfg_data (no read-back)
//
// Streaming bytes pass one per cycle while the output register frees; a result appears in the cycle after its beat.
// After the 34th header byte of a passing frame the header image drains from the burst buffer:
// up to 34 beats, or 54 with the tunnel (fewer when the limit cuts inside it),
// one per cycle while the output register frees, and input is held off meanwhile.
// Reset is synchronous; no clearing pass.
// Output stalls hold off the burst and every streaming beat, cut-off bytes included;
// header bytes and bytes of dropped frames keep flowing.
`default_nettype none

module ipv4_packet_rewrite_tunnel_top #(
  parameter int LENGTH_BITS = iprt_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  iprt_pkg::in_beat_t                    in_beat,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output iprt_pkg::out_beat_t                   out_beat,
  input  logic                                  cfg_we,
  input  logic [iprt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [iprt_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import iprt_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  push_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dst_rewrite_enable <= 1'b0;
      cfg.new_dst_addr       <= '0;
      cfg.tunnel_enable      <= 1'b0;
      cfg.outer_src_addr     <= '0;
      cfg.outer_dst_addr     <= '0;
      cfg.mtu_limit          <= MTU_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DST_REWRITE_EN: cfg.dst_rewrite_enable <= cfg_data[0];
        CFG_NEW_DST_ADDR:   cfg.new_dst_addr       <= cfg_data[31:0];
        CFG_TUNNEL_EN:      cfg.tunnel_enable      <= cfg_data[0];
        CFG_OUTER_SRC:      cfg.outer_src_addr     <= cfg_data[31:0];
        CFG_OUTER_DST:      cfg.outer_dst_addr     <= cfg_data[31:0];
        CFG_MTU_LIMIT:      cfg.mtu_limit          <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  iprt_frame_ctl #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_ctl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .cfg        (cfg),
    .push       (push),
    .push_ready (push_ready)
  );

  iprt_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_beat   (out_beat)
  );

endmodule

`default_nettype wire

FILE: rtl/iprt_hdr_build.sv
// Header check, rewrite, truncation and outer-header construction (combinational).
`default_nettype none

module iprt_hdr_build (
  input  iprt_pkg::hdr_bytes_t hdr,
  input  logic                 frame_end,
  input  logic [15:0]          held_wire_length,
  input  iprt_pkg::cfg_t       cfg,
  output iprt_pkg::build_t     build
);
  import iprt_pkg::*;

  logic [15:0]                ethertype;
  logic [15:0]                ip_len;
  logic [15:0]                new_len;
  logic [15:0]                len_used;
  logic [15:0]                outer_len;
  logic [16:0]                ip_len_eth;
  logic [16:0]                total;
  logic [16:0]                wl_ext;
  logic [15:0]                wl_cut;
  logic                       cut;
  logic                       is_l4;
  logic                       short_cut;
  logic [CNT_BITS-1:0]        full_cnt;
  hdr_bytes_t                 hr;
  logic [TUN_BYTES-1:0][7:0]  outer;

  // Checks and length handling
  always_comb begin
    ethertype  = {hdr[ETYPE_HI], hdr[ETYPE_LO]};
    is_l4      = (hdr[PROTO_POS] == PROTO_TCP) || (hdr[PROTO_POS] == PROTO_UDP);
    ip_len     = {hdr[LEN_HI], hdr[LEN_LO]};
    ip_len_eth = {1'b0, ip_len} + 17'(ETH_BYTES);
    cut        = ip_len_eth > {1'b0, cfg.mtu_limit};
    new_len    = cfg.mtu_limit - 16'(ETH_BYTES);
    len_used   = cut ? new_len : ip_len;
    outer_len  = len_used + 16'(TUN_BYTES);
  end

  // Rewritten inner header and outer header
  always_comb begin
    hr = hdr;
    if (cfg.dst_rewrite_enable) begin
      for (int i = 0; i < 4; i++) begin
        hr[DST_POS + i] = cfg.new_dst_addr[8*(3-i) +: 8];
      end
    end
    if (cut) begin
      hr[LEN_HI] = new_len[15:8];
      hr[LEN_LO] = new_len[7:0];
    end

    for (int i = 0; i < TUN_BYTES; i++) begin
      outer[i] = hr[ETH_BYTES + i];
    end
    outer[0]              = VER_IHL;
    outer[OUT_LEN_HI]     = outer_len[15:8];
    outer[OUT_LEN_HI + 1] = outer_len[7:0];
    outer[OUT_TTL]        = OUTER_TTL;
    outer[OUT_PROTO]      = PROTO_IPIP;
    for (int i = 0; i < 4; i++) begin
      outer[OUT_SRC + i] = cfg.outer_src_addr[8*(3-i) +: 8];
      outer[OUT_DST + i] = cfg.outer_dst_addr[8*(3-i) +: 8];
    end
  end

  // Output image, beat count, last mark and adjusted wire length
  always_comb begin
    build.image = '0;
    for (int i = 0; i < ETH_BYTES; i++) begin
      build.image[i] = hr[i];
    end
    if (cfg.tunnel_enable) begin
      for (int i = 0; i < TUN_BYTES; i++) begin
        build.image[ETH_BYTES + i] = outer[i];
      end
      for (int i = 0; i < HEADER_BYTES - ETH_BYTES; i++) begin
        build.image[ETH_BYTES + TUN_BYTES + i] = hr[ETH_BYTES + i];
      end
    end else begin
      for (int i = 0; i < HEADER_BYTES - ETH_BYTES; i++) begin
        build.image[ETH_BYTES + i] = hr[ETH_BYTES + i];
      end
    end

    full_cnt  = cfg.tunnel_enable ? CNT_BITS'(IMAGE_BYTES) : CNT_BITS'(HEADER_BYTES);
    total     = {1'b0, cfg.mtu_limit} + (cfg.tunnel_enable ? 17'(TUN_BYTES) : 17'd0);
    short_cut = cut && (total < 17'(full_cnt));

    build.count = short_cut ? total[CNT_BITS-1:0] : full_cnt;
    build.last  = (frame_end && !short_cut) || (cut && (total <= 17'(full_cnt)));
    build.pass  = (ethertype == ETHERTYPE_IPV4) && (hdr[VER_IHL_POS][3:0] >= IHL_MIN) && is_l4;
    build.cut   = cut;

    wl_cut = (cut && (held_wire_length > cfg.mtu_limit)) ? cfg.mtu_limit : held_wire_length;
    wl_ext = {1'b0, wl_cut} + 17'(TUN_BYTES);
    if (!cfg.tunnel_enable) begin
      build.wire_length = wl_cut;
    end else if (wl_ext[16]) begin
      build.wire_length = 16'hFFFF;
    end else begin
      build.wire_length = wl_ext[15:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/iprt_frame_ctl.sv
// Frame phase control, header shift line and header burst buffer.
`default_nettype none

module iprt_frame_ctl #(
  parameter int LENGTH_BITS = iprt_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  iprt_pkg::in_beat_t in_beat,
  input  iprt_pkg::cfg_t     cfg,
  output iprt_pkg::push_t    push,
  input  logic               push_ready
);
  import iprt_pkg::*;

  localparam int CMP_BITS = 17;
  localparam logic [LENGTH_BITS-1:0] POS_MAX = '1;

  phase_t                           phase;
  phase_t                           phase_next;
  logic [LENGTH_BITS-1:0]           byte_pos;
  logic [15:0]                      emit_limit;
  logic [15:0]                      held_wl;
  logic [HEADER_BYTES-2:0][7:0]     hdr_line;
  image_t                           burst_img;
  logic [CNT_BITS-1:0]              burst_cnt;
  logic                             burst_last;

  logic                             accept;
  logic                             hdr_done;
  logic                             burst_busy;
  logic                             stream_emit;
  logic                             stream_last;
  logic                             beat_end;
  hdr_bytes_t                       hdr_full;
  build_t                           build;

  assign hdr_full = {in_beat.data_byte, hdr_line};
  assign hdr_done = (phase == PH_COLLECT) && (byte_pos == LENGTH_BITS'(HEADER_BYTES - 1));

  iprt_hdr_build u_build (
    .hdr              (hdr_full),
    .frame_end        (in_beat.frame_end),
    .held_wire_length (held_wl),
    .cfg              (cfg),
    .build            (build)
  );

  // Next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      case (phase)
        PH_COLLECT: begin
          if (hdr_done) begin
            if (in_beat.frame_end) begin
              phase_next = PH_COLLECT;
            end else if (!build.pass) begin
              phase_next = PH_DROP;
            end else if (build.cut) begin
              phase_next = PH_STREAM_CUT;
            end else begin
              phase_next = PH_STREAM;
            end
          end
        end
        PH_DROP, PH_STREAM, PH_STREAM_CUT: begin
          if (in_beat.frame_end) begin
            phase_next = PH_COLLECT;
          end
        end
        default: phase_next = PH_COLLECT;
      endcase
    end
  end

  // Handshake and beat offered to the output register
  always_comb begin
    burst_busy  = burst_cnt != '0;
    in_ready    = !burst_busy && (push_ready || (phase inside {PH_COLLECT, PH_DROP}));
    accept      = in_valid && in_ready;
    stream_emit = (phase == PH_STREAM) ||
                  ((phase == PH_STREAM_CUT) &&
                   (CMP_BITS'(byte_pos) < CMP_BITS'(emit_limit)));
    stream_last = in_beat.frame_end ||
                  ((phase == PH_STREAM_CUT) &&
                   (CMP_BITS'(byte_pos) + CMP_BITS'(1) == CMP_BITS'(emit_limit)));

    if (burst_busy) begin
      push.valid         = 1'b1;
      push.beat.out_byte = burst_img[0];
      beat_end           = burst_last && (burst_cnt == CNT_BITS'(1));
    end else begin
      push.valid         = accept && (phase inside {PH_STREAM, PH_STREAM_CUT}) && stream_emit;
      push.beat.out_byte = in_beat.data_byte;
      beat_end           = stream_last;
    end
    push.beat.out_end         = beat_end;
    push.beat.out_wire_length = beat_end ? held_wl : 16'd0;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_COLLECT;
      byte_pos   <= '0;
      emit_limit <= '0;
      held_wl    <= '0;
      burst_cnt  <= '0;
      burst_last <= 1'b0;
    end else begin
      phase <= phase_next;
      if (burst_busy && push_ready) begin
        burst_cnt <= burst_cnt - CNT_BITS'(1);
      end
      if (accept) begin
        case (phase)
          PH_COLLECT: begin
            byte_pos <= in_beat.frame_end ? '0 : byte_pos + LENGTH_BITS'(1);
            // header complete and passing: load the burst and the frame's length state
            if (hdr_done && build.pass) begin
              burst_cnt  <= build.count;
              burst_last <= build.last;
              held_wl    <= build.wire_length;
              emit_limit <= (build.cut && !in_beat.frame_end) ? cfg.mtu_limit : 16'd0;
            end else begin
              if (byte_pos == '0) begin
                held_wl <= in_beat.wire_length;
              end
              if (in_beat.frame_end) begin
                emit_limit <= '0;
              end
            end
          end
          PH_DROP: begin
            if (in_beat.frame_end) begin
              byte_pos <= '0;
            end
          end
          default: begin
            if (in_beat.frame_end) begin
              byte_pos   <= '0;
              emit_limit <= '0;
            end else if (byte_pos != POS_MAX) begin
              byte_pos <= byte_pos + LENGTH_BITS'(1);
            end
          end
        endcase
      end
    end
  end

  // Header shift line and burst buffer
  always_ff @(posedge clk) begin
    if (accept && (phase == PH_COLLECT)) begin
      hdr_line <= {in_beat.data_byte, hdr_line[HEADER_BYTES-2:1]};
    end
    if (accept && hdr_done) begin
      burst_img <= build.image;
    end else if (burst_busy && push_ready) begin
      burst_img <= {8'h00, burst_img[IMAGE_BYTES-1:1]};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/iprt_out_stage.sv
// Output register between the frame controller and the result channel.
`default_nettype none

module iprt_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  iprt_pkg::push_t     push,
  output logic                push_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output iprt_pkg::out_beat_t out_beat
);
  import iprt_pkg::*;

  assign push_ready = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push.valid && push_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (push.valid && push_ready) begin
      out_beat <= push.beat;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/iprt_checker.sv
// Port-level checker for the rewriter top level, attached by bind.
`default_nettype none

module iprt_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input iprt_pkg::out_beat_t out_beat
);
  import iprt_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("result beat changed while stalled");

  // Wire length is only reported on the closing beat
  a_len_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_beat.out_end |-> out_beat.out_wire_length == 16'd0)
    else $error("wire length on a beat that is not the last");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ipv4_packet_rewrite_tunnel_top iprt_checker u_iprt_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_beat  (out_beat)
);

`default_nettype wire
